// ===== rtl/core/lookahead_peak_limiter_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lookahead peak limiter core
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef LOOKAHEAD_PEAK_LIMITER_CORE_MACROS_SVH
`define LOOKAHEAD_PEAK_LIMITER_CORE_MACROS_SVH

// Same-cycle implication.
`define LPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpl_pkg.sv =====
// ---------------------------------------------------------------------------
// Lookahead peak limiter package
// Shared widths, register map, configuration record, divider status and a magnitude helper.
// ---------------------------------------------------------------------------
package lpl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int HIST_AW     = 16;
  localparam int SMOOTH_AW   = HIST_AW - 1;
  localparam int CNT_W       = HIST_AW + 1;
  localparam int FS_W        = 39;
  localparam int SS_W        = 54;
  localparam int DIV_STEPS   = SAMPLE_BITS - 1;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int PADDR_W     = 5;

  localparam logic [SAMPLE_BITS-1:0] UNITY = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [CNT_W-1:0] DEQ_DEPTH = {1'b1, {HIST_AW{1'b0}}};

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_RELEASE   = 3'd1,
    REG_HOLD      = 3'd2,
    REG_ATTACK    = 3'd3,
    REG_SCALE     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] threshold;
    logic [31:0] release_factor;
    logic [15:0] hold_frames;
    logic [14:0] attack_half;
    logic [31:0] smooth_scale;
  } cfg_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] quot;
  } div_stat_t;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
    return raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  endfunction

endpackage

// ===== rtl/core/lpl_ram.sv =====
// ---------------------------------------------------------------------------
// Lookahead peak limiter RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module lpl_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lpl_regs.sv =====
// ---------------------------------------------------------------------------
// Lookahead peak limiter configuration registers
// APB-style register file holding the five limiter settings.
// ---------------------------------------------------------------------------
module lpl_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lpl_pkg::cfg_t               cfg
);
  import lpl_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= 24'd8388608;
      cfg_r.release_factor <= 32'd16777216;
      cfg_r.hold_frames    <= 16'd1;
      cfg_r.attack_half    <= 15'd1;
      cfg_r.smooth_scale   <= 32'h8000_0000;
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD: cfg_r.threshold      <= pwdata[23:0];
        REG_RELEASE:   cfg_r.release_factor <= pwdata;
        REG_HOLD:      cfg_r.hold_frames    <= pwdata[15:0];
        REG_ATTACK:    cfg_r.attack_half    <= pwdata[14:0];
        REG_SCALE:     cfg_r.smooth_scale   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = {8'd0, cfg_r.threshold};
      REG_RELEASE:   prdata = cfg_r.release_factor;
      REG_HOLD:      prdata = {16'd0, cfg_r.hold_frames};
      REG_ATTACK:    prdata = {17'd0, cfg_r.attack_half};
      REG_SCALE:     prdata = cfg_r.smooth_scale;
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/lpl_div.sv =====
// ---------------------------------------------------------------------------
// Lookahead peak limiter gain divider
// Restoring divider giving threshold * unity / peak (unity when peak <= threshold), one quotient bit a cycle.
// ---------------------------------------------------------------------------
module lpl_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lpl_pkg::SAMPLE_BITS-1:0] numer,
  input  logic [lpl_pkg::SAMPLE_BITS-1:0] denom,
  output lpl_pkg::div_stat_t              stat
);
  import lpl_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [SAMPLE_BITS:0]   rem_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [DIV_STEPS-1:0]   quo_r;
  logic [SAMPLE_BITS-1:0] res_r;
  logic [SAMPLE_BITS:0]   shifted;
  logic                   qbit;
  logic [DIV_STEPS-1:0]   quo_nxt;

  assign shifted = {rem_r[SAMPLE_BITS-1:0], 1'b0};
  assign qbit    = shifted >= {1'b0, den_r};
  assign quo_nxt = {quo_r[DIV_STEPS-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (denom > numer) begin
          busy_r <= 1'b1;
          cnt_r  <= DIV_CNT_W'(DIV_STEPS);
        end else begin
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, numer};
      den_r <= denom;
      quo_r <= '0;
      res_r <= UNITY;
    end else if (busy_r) begin
      rem_r <= qbit ? (shifted - {1'b0, den_r}) : shifted;
      quo_r <= quo_nxt;
      res_r <= {1'b0, quo_nxt};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = res_r;

endmodule

// ===== rtl/core/lookahead_peak_limiter_core.sv =====
// ---------------------------------------------------------------------------
// Lookahead peak limiter core
// Sliding-peak gain computer, double boxcar smoother and lookahead delay,
// with all history held in synchronous RAMs.
//
//   Channel  Signals                                   Direction
//   in       in_valid/in_ready, in_sample_in           sink
//   out      out_valid/out_ready, out_sample_out,      source
//            out_peak_level, out_smoothed_gain
//   cfg      psel/penable/pwrite/paddr/pwdata/prdata   APB slave
//
// An item's time grows by a read state and a compare state per deque entry
// popped from the tail; the gain divider runs only when the held peak is
// above threshold, and the single read port of each RAM serializes its reads.
// After reset a clearing pass zeroes all RAMs before the first item is taken.
// A new item is taken while the last result is still waiting; it then stalls
// in its final state until the output is free.
// ---------------------------------------------------------------------------
`include "lookahead_peak_limiter_core_macros.svh"

module lookahead_peak_limiter_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lpl_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lpl_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic        [lpl_pkg::SAMPLE_BITS-1:0] out_peak_level,
  output logic        [lpl_pkg::SAMPLE_BITS-1:0] out_smoothed_gain,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [lpl_pkg::PADDR_W-1:0]     paddr,
  input  logic        [31:0]                     pwdata,
  output logic        [31:0]                     prdata,
  output logic                                   pready
);
  import lpl_pkg::*;

  typedef enum logic [22:0] {
    ST_CLEAR    = 23'd1 << 0,
    ST_IDLE     = 23'd1 << 1,
    ST_RD_EXP   = 23'd1 << 2,
    ST_RD_DLY   = 23'd1 << 3,
    ST_POP_RD   = 23'd1 << 4,
    ST_POP_CMP  = 23'd1 << 5,
    ST_PUSH     = 23'd1 << 6,
    ST_HD_RD    = 23'd1 << 7,
    ST_HD_CMP   = 23'd1 << 8,
    ST_PK_RD    = 23'd1 << 9,
    ST_PK_GET   = 23'd1 << 10,
    ST_DIV_GO   = 23'd1 << 11,
    ST_DIV_WAIT = 23'd1 << 12,
    ST_GAIN     = 23'd1 << 13,
    ST_SM_RD    = 23'd1 << 14,
    ST_SM1      = 23'd1 << 15,
    ST_SM2      = 23'd1 << 16,
    ST_SC_LO    = 23'd1 << 17,
    ST_SC_HI    = 23'd1 << 18,
    ST_SC_SUM   = 23'd1 << 19,
    ST_OUT_MUL  = 23'd1 << 20,
    ST_OUT      = 23'd1 << 21,
    ST_DONE     = 23'd1 << 22
  } state_t;

  state_t state_r, state_nxt;
  cfg_t   cfg;

  logic [HIST_AW-1:0]     clr_cnt_r;
  logic [HIST_AW-1:0]     wi_r;
  logic [HIST_AW-1:0]     head_r;
  logic [HIST_AW-1:0]     tail_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SMOOTH_AW-1:0]   si_r;
  logic [SAMPLE_BITS-1:0] gain_r;
  logic [FS_W-1:0]        fs_r;
  logic [SS_W-1:0]        ss_r;
  logic [SS_W-1:0]        ssp_r;
  logic                   out_valid_r;

  logic [SAMPLE_BITS-1:0] raw_r;
  logic [SAMPLE_BITS-1:0] exp_r;
  logic [SAMPLE_BITS-1:0] dly_r;
  logic [SAMPLE_BITS-1:0] peak_r;
  logic [SAMPLE_BITS-1:0] sm_r;
  logic [31:0]            plo_r;
  logic [63:0]            mul_r;
  logic [SAMPLE_BITS-1:0] res_sample_r;
  logic [SAMPLE_BITS-1:0] res_peak_r;
  logic [SAMPLE_BITS-1:0] res_gain_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic [SAMPLE_BITS-1:0] out_peak_r;
  logic [SAMPLE_BITS-1:0] out_gain_r;

  logic                   clearing;
  logic                   slot_free;
  logic [SAMPLE_BITS-1:0] x0;
  logic [HIST_AW-1:0]     look;
  logic [31:0]            mul_a, mul_b;
  div_stat_t              div_stat;
  logic                   div_start;

  logic                   ih_we, pd_we, gh_we, fsh_we;
  logic [HIST_AW-1:0]     ih_waddr, ih_raddr, pd_waddr, pd_raddr;
  logic [SMOOTH_AW-1:0]   sm_waddr, gh_raddr, fsh_raddr;
  logic [SAMPLE_BITS-1:0] ih_wdata, ih_q, pd_wdata, pd_q, gh_wdata, gh_q;
  logic [FS_W-1:0]        fsh_wdata, fsh_q;

  logic [31:0]            rel;
  logic [SAMPLE_BITS-1:0] rel_sat;
  logic [FS_W:0]          fs_sum;
  logic [FS_W-1:0]        d2;
  logic [SS_W:0]          ss_sum;
  logic [SS_W:0]          sc_sum;
  logic [SAMPLE_BITS:0]   prod;

  lpl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (cfg.threshold),
    .denom (peak_r),
    .stat  (div_stat)
  );

  assign clearing  = state_r == ST_CLEAR;
  assign x0        = magnitude(raw_r);
  assign look      = {cfg.attack_half, 1'b0};
  assign div_start = state_r == ST_DIV_GO;
  assign slot_free = !out_valid_r || out_ready;

  assign ih_we     = clearing || state_r == ST_RD_DLY;
  assign ih_waddr  = clearing ? clr_cnt_r : wi_r;
  assign ih_wdata  = clearing ? '0 : raw_r;
  assign ih_raddr  = (state_r == ST_RD_EXP) ? (wi_r - look) : (wi_r - cfg.hold_frames);

  assign pd_we     = clearing || state_r == ST_PUSH;
  assign pd_waddr  = clearing ? clr_cnt_r : tail_r;
  assign pd_wdata  = clearing ? '0 : x0;
  assign pd_raddr  = (state_r == ST_POP_RD) ? (tail_r - 1'b1) : head_r;

  assign sm_waddr  = clearing ? clr_cnt_r[SMOOTH_AW-1:0] : si_r;
  assign gh_we     = clearing || state_r == ST_SM1;
  assign gh_wdata  = clearing ? '0 : gain_r;
  assign gh_raddr  = si_r - cfg.attack_half - 1'b1;
  assign fsh_we    = clearing || state_r == ST_SM2;
  assign fsh_wdata = clearing ? '0 : fs_r;
  assign fsh_raddr = si_r - cfg.attack_half;

  lpl_ram #(.AW(HIST_AW), .DW(SAMPLE_BITS)) u_input_hist (
    .clk (clk), .we (ih_we), .waddr (ih_waddr), .wdata (ih_wdata),
    .raddr (ih_raddr), .rdata (ih_q)
  );

  lpl_ram #(.AW(HIST_AW), .DW(SAMPLE_BITS)) u_peak_deque (
    .clk (clk), .we (pd_we), .waddr (pd_waddr), .wdata (pd_wdata),
    .raddr (pd_raddr), .rdata (pd_q)
  );

  lpl_ram #(.AW(SMOOTH_AW), .DW(SAMPLE_BITS)) u_gain_hist (
    .clk (clk), .we (gh_we), .waddr (sm_waddr), .wdata (gh_wdata),
    .raddr (gh_raddr), .rdata (gh_q)
  );

  lpl_ram #(.AW(SMOOTH_AW), .DW(FS_W)) u_first_sum_hist (
    .clk (clk), .we (fsh_we), .waddr (sm_waddr), .wdata (fsh_wdata),
    .raddr (fsh_raddr), .rdata (fsh_q)
  );

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      ST_SC_LO: begin
        mul_a = ssp_r[31:0];
        mul_b = cfg.smooth_scale;
      end
      ST_SC_HI: begin
        mul_a = {{(64-SS_W){1'b0}}, ssp_r[SS_W-1:32]};
        mul_b = cfg.smooth_scale;
      end
      ST_OUT_MUL: begin
        mul_a = {8'd0, sm_r};
        mul_b = {8'd0, magnitude(dly_r)};
      end
      default: begin
        mul_a = {8'd0, gain_r};
        mul_b = cfg.release_factor;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  assign rel     = mul_r[55:24];
  assign rel_sat = (rel > {8'd0, UNITY}) ? UNITY : rel[SAMPLE_BITS-1:0];
  assign fs_sum  = {1'b0, fs_r} + {{(FS_W+1-SAMPLE_BITS){1'b0}}, gain_r};
  assign d2      = (cfg.attack_half == '0) ? fs_r : fsh_q;
  assign ss_sum  = {1'b0, ss_r} + {{(SS_W+1-FS_W){1'b0}}, fs_r};
  assign sc_sum  = {1'b0, mul_r[SS_W-1:0]} + {{(SS_W+1-32){1'b0}}, plo_r};
  assign prod    = mul_r[2*SAMPLE_BITS-1:SAMPLE_BITS-1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_RD_EXP;
      ST_RD_EXP:   state_nxt = ST_RD_DLY;
      ST_RD_DLY:   state_nxt = ST_POP_RD;
      ST_POP_RD:   state_nxt = (cnt_r == '0) ? ST_PUSH : ST_POP_CMP;
      ST_POP_CMP:  state_nxt = (pd_q >= x0) ? ST_PUSH : ST_POP_RD;
      ST_PUSH:     state_nxt = ST_HD_RD;
      ST_HD_RD:    state_nxt = ST_HD_CMP;
      ST_HD_CMP:   state_nxt = (pd_q == exp_r) ? ST_PK_RD : ST_DIV_GO;
      ST_PK_RD:    state_nxt = ST_PK_GET;
      ST_PK_GET:   state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_stat.done) state_nxt = ST_GAIN;
      ST_GAIN:     state_nxt = ST_SM_RD;
      ST_SM_RD:    state_nxt = ST_SM1;
      ST_SM1:      state_nxt = ST_SM2;
      ST_SM2:      state_nxt = ST_SC_LO;
      ST_SC_LO:    state_nxt = ST_SC_HI;
      ST_SC_HI:    state_nxt = ST_SC_SUM;
      ST_SC_SUM:   state_nxt = ST_OUT_MUL;
      ST_OUT_MUL:  state_nxt = ST_OUT;
      ST_OUT:      state_nxt = ST_DONE;
      ST_DONE:     if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      wi_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      si_r        <= '0;
      gain_r      <= UNITY;
      fs_r        <= '0;
      ss_r        <= '0;
      ssp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_CLEAR:   clr_cnt_r <= clr_cnt_r + 1'b1;
        ST_RD_DLY:  wi_r <= wi_r + 1'b1;
        ST_POP_CMP: begin
          if (pd_q < x0) begin
            tail_r <= tail_r - 1'b1;
            cnt_r  <= cnt_r - 1'b1;
          end
        end
        ST_PUSH: begin
          tail_r <= tail_r + 1'b1;
          if (cnt_r == DEQ_DEPTH) begin
            head_r <= head_r + 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_HD_CMP: begin
          if (pd_q == exp_r) begin
            head_r <= head_r + 1'b1;
            cnt_r  <= cnt_r - 1'b1;
          end
        end
        ST_GAIN: gain_r <= (div_stat.quot < rel_sat) ? div_stat.quot : rel_sat;
        ST_SM1: begin
          fs_r <= (fs_sum >= {{(FS_W+1-SAMPLE_BITS){1'b0}}, gh_q}) ?
                  FS_W'(fs_sum - {{(FS_W+1-SAMPLE_BITS){1'b0}}, gh_q}) : '0;
        end
        ST_SM2: begin
          ss_r <= (ss_sum >= {{(SS_W+1-FS_W){1'b0}}, d2}) ?
                  SS_W'(ss_sum - {{(SS_W+1-FS_W){1'b0}}, d2}) : '0;
          si_r <= si_r + 1'b1;
        end
        ST_SC_SUM: ssp_r <= ss_r;
        default: ;
      endcase
      if (state_r == ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE:   raw_r <= in_sample_in;
      ST_RD_EXP: exp_r <= (cfg.hold_frames == '0) ? x0 : magnitude(ih_q);
      ST_RD_DLY: dly_r <= (look == '0) ? raw_r : ih_q;
      ST_HD_CMP: peak_r <= (cfg.hold_frames == '0) ? '0 : pd_q;
      ST_PK_GET: peak_r <= (cnt_r == '0 || cfg.hold_frames == '0) ? '0 : pd_q;
      ST_SC_HI:  plo_r <= mul_r[63:32];
      ST_SC_SUM: sm_r <= (sc_sum > {{(SS_W+1-SAMPLE_BITS){1'b0}}, UNITY}) ?
                         UNITY : sc_sum[SAMPLE_BITS-1:0];
      ST_OUT: begin
        if (dly_r[SAMPLE_BITS-1]) begin
          res_sample_r <= (prod > {1'b0, UNITY}) ? UNITY :
                          SAMPLE_BITS'(~prod + 1'b1);
        end else begin
          res_sample_r <= (prod > {1'b0, UNITY - 1'b1}) ? (UNITY - 1'b1) :
                          prod[SAMPLE_BITS-1:0];
        end
        res_peak_r <= peak_r;
        res_gain_r <= sm_r;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_sample_r <= res_sample_r;
          out_peak_r   <= res_peak_r;
          out_gain_r   <= res_gain_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready          = state_r == ST_IDLE;
  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_peak_level    = out_peak_r;
  assign out_smoothed_gain = out_gain_r;

  `LPL_ASSERT_IMP(a_deque_bound, 1'b1, cnt_r <= DEQ_DEPTH, "deque count exceeds depth")
  `LPL_ASSERT_IMP(a_gain_range, 1'b1, gain_r <= UNITY, "gain level above unity")
  `LPL_ASSERT_IMP(a_div_done_wait, div_stat.done, state_r == ST_DIV_WAIT, "divider result unused")
  `LPL_ASSERT_NXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid_r), "result too early")

endmodule

// ===== tb/lpl_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Lookahead peak limiter checker
// Watches the configuration port and both item channels, predicts every
// result of the limiter from its own model of the deque, gain computer and
// double boxcar smoother, and compares each result item field by field.
// ---------------------------------------------------------------------------
module lpl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [23:0] in_sample_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [23:0] out_sample_out,
  input  logic [23:0] out_peak_level,
  input  logic [23:0] out_smoothed_gain,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lpl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import lpl_pkg::*;

  localparam logic [63:0] ONE = 64'd8388608;

  typedef struct packed {
    logic [23:0] sample;
    logic [23:0] peak;
    logic [23:0] gain;
  } limited_t;

  limited_t    limited_buf[64];
  int          put_cnt = 0;
  int          take_cnt = 0;
  cfg_t        cfg;
  logic [63:0] gain_level;
  logic [23:0] sample_hist[65536];
  logic [23:0] peak_dq[65536];
  logic [23:0] gain_hist[32768];
  logic [63:0] fsum_hist[32768];
  logic [15:0] wr_idx, dq_head, dq_tail;
  int          dq_count;
  logic [14:0] sm_idx;
  logic [63:0] fsum, ssum, ssum_prev;

  function automatic logic [63:0] mag(input logic [23:0] raw);
    return raw[23] ? 64'd16777216 - 64'(raw) : 64'(raw);
  endfunction

  task automatic limit_sample(input logic [23:0] raw);
    logic [63:0] x0, expiring, peak, cand, rel, d1, d2, hi, lo, smoothed, prod, m;
    logic [23:0] delayed_raw;
    logic [15:0] hold, look, last;
    logic [14:0] half;
    limited_t    res;
    x0 = mag(raw);
    hold = cfg.hold_frames;
    half = cfg.attack_half;
    look = {half, 1'b0};
    expiring = (hold == 0) ? x0 : mag(sample_hist[wr_idx - hold]);
    delayed_raw = (look == 0) ? raw : sample_hist[wr_idx - look];
    sample_hist[wr_idx] = raw;
    wr_idx = wr_idx + 1'b1;

    while (dq_count > 0) begin
      last = dq_tail - 1'b1;
      if (64'(peak_dq[last]) >= x0) break;
      dq_tail = last;
      dq_count--;
    end
    if (dq_count >= 65536) begin
      dq_head = dq_head + 1'b1;
      dq_count--;
    end
    peak_dq[dq_tail] = x0[23:0];
    dq_tail = dq_tail + 1'b1;
    dq_count++;
    if (dq_count > 0 && 64'(peak_dq[dq_head]) == expiring) begin
      dq_head = dq_head + 1'b1;
      dq_count--;
    end
    peak = (dq_count > 0) ? 64'(peak_dq[dq_head]) : 64'd0;
    if (hold == 0) peak = 0;

    cand = (peak > 64'(cfg.threshold)) ? (64'(cfg.threshold) << 23) / peak : ONE;
    rel = (gain_level * 64'(cfg.release_factor)) >> 24;
    if (rel > ONE) rel = ONE;
    gain_level = (cand < rel) ? cand : rel;

    d1 = 64'(gain_hist[sm_idx - 15'(16'(half) + 16'd1)]);
    gain_hist[sm_idx] = gain_level[23:0];
    fsum = fsum + gain_level;
    fsum = (fsum >= d1) ? fsum - d1 : 64'd0;
    d2 = (half == 0) ? fsum : fsum_hist[sm_idx - half];
    fsum_hist[sm_idx] = fsum;
    ssum = ssum + fsum;
    ssum = (ssum >= d2) ? ssum - d2 : 64'd0;
    sm_idx = sm_idx + 1'b1;

    hi = ssum_prev >> 32;
    lo = ssum_prev & 64'hFFFF_FFFF;
    if (hi != 0 && cfg.smooth_scale != 0 && hi > (ONE / 64'(cfg.smooth_scale)) + 1) begin
      smoothed = ONE;
    end else begin
      smoothed = hi * 64'(cfg.smooth_scale) + ((lo * 64'(cfg.smooth_scale)) >> 32);
      if (smoothed > ONE) smoothed = ONE;
    end
    ssum_prev = ssum;

    m = mag(delayed_raw);
    prod = (smoothed * m) >> 23;
    if (delayed_raw[23]) begin
      if (prod > ONE) prod = ONE;
      res.sample = 24'(64'd0 - prod);
    end else begin
      if (prod > ONE - 1) prod = ONE - 1;
      res.sample = prod[23:0];
    end
    res.peak = peak[23:0];
    res.gain = smoothed[23:0];
    limited_buf[put_cnt % 64] = res;
    put_cnt++;
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < 65536; i++) begin
      sample_hist[i] = '0;
      peak_dq[i] = '0;
    end
    for (int i = 0; i < 32768; i++) begin
      gain_hist[i] = '0;
      fsum_hist[i] = '0;
    end
  end

  assign pending = put_cnt - take_cnt;

  always @(posedge clk) begin
    limited_t want;
    if (!rst_n) begin
      cfg.threshold <= 24'd8388608;
      cfg.release_factor <= 32'd16777216;
      cfg.hold_frames <= 16'd1;
      cfg.attack_half <= 15'd1;
      cfg.smooth_scale <= 32'h8000_0000;
      gain_level = ONE;
      wr_idx = '0;
      dq_head = '0;
      dq_tail = '0;
      dq_count = 0;
      sm_idx = '0;
      fsum = '0;
      ssum = '0;
      ssum_prev = '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[lpl_pkg::PADDR_W-1:2])
          REG_THRESHOLD: cfg.threshold <= pwdata[23:0];
          REG_RELEASE:   cfg.release_factor <= pwdata;
          REG_HOLD:      cfg.hold_frames <= pwdata[15:0];
          REG_ATTACK:    cfg.attack_half <= pwdata[14:0];
          REG_SCALE:     cfg.smooth_scale <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) limit_sample(in_sample_in);
      if (out_valid && out_ready) begin
        if (put_cnt == take_cnt) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item: sample %h", out_sample_out);
        end else begin
          want = limited_buf[take_cnt % 64];
          take_cnt++;
          if (want.sample !== out_sample_out || want.peak !== out_peak_level ||
              want.gain !== out_smoothed_gain) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h/%h/%h, got %h/%h/%h", want.sample, want.peak,
                       want.gain, out_sample_out, out_peak_level, out_smoothed_gain);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Lookahead peak limiter regression
// Drives sample items under several register settings and idling patterns,
// including a long output hold-off, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_top;
  import lpl_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [23:0] in_sample_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [23:0] out_sample_out;
  logic [23:0] out_peak_level, out_smoothed_gain;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic        pready;
  int          fail_count, pending;
  int          snd_idle = 0, rcv_stall = 0, hold_off = 0;
  logic        hold_go = 1'b0, hold_seen = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lookahead_peak_limiter_core dut (.*);

  lpl_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample_in, .out_valid, .out_ready,
    .out_sample_out, .out_peak_level, .out_smoothed_gain, .psel, .penable, .pwrite,
    .paddr, .pwdata, .fail_count, .pending
  );

  initial begin
    #50_000_000;
    $display("lookahead_peak_limiter_core regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_off <= 600;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limiter(input logic [23:0] thr, input logic [31:0] rf,
                             input logic [15:0] hold, input logic [14:0] att);
    logic [63:0] scale;
    scale = 64'h1_0000_0000 / (64'(att) * (64'(att) + 1));
    reg_write({REG_THRESHOLD, 2'b00}, 32'(thr));
    reg_write({REG_RELEASE, 2'b00}, rf);
    reg_write({REG_HOLD, 2'b00}, 32'(hold));
    reg_write({REG_ATTACK, 2'b00}, 32'(att));
    reg_write({REG_SCALE, 2'b00}, scale[31:0]);
  endtask

  task automatic send_sample(input logic [23:0] s);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [23:0] random_sample(input int style);
    logic [31:0] r;
    r = $urandom;
    case (style)
      0: return r[23:0];
      1: return 24'($signed(r[23:0]) >>> $urandom_range(12, 4));
      2: return r[0] ? 24'h800000 + 24'(r[9:1]) : 24'h7FFFFF - 24'(r[9:1]);
      default: return 24'($signed(r[23:0]) >>> $urandom_range(3, 1));
    endcase
  endfunction

  initial begin
    int mode, style, n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reg_write(5'd24, 32'hFFFF_FFFF);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    send_sample(24'h800000);
    drain();
    set_limiter(24'd4194304, 32'd16777216 + 32'd2000, 16'd0, 15'd1);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h400000);
    drain();
    set_limiter(24'd1, 32'hFFFF_FFFF, 16'd6, 15'd2);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 24'h800000 : 24'h100000 >> i);
    drain();
    reg_write({REG_SCALE, 2'b00}, 32'd1);
    for (int i = 0; i < 4; i++) send_sample(24'h7FFFFF);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      mode = ph % 4;
      snd_idle = (mode == 1 || mode == 3) ? 85 : 0;
      rcv_stall = (mode == 2 || mode == 3) ? 85 : 0;
      if (mode == 3) begin
        snd_idle = 7;
        rcv_stall = 7;
      end
      case (ph)
        4: set_limiter(24'd8388608, 32'd16777216, 16'd65535, 15'd32767);
        7: set_limiter(24'd1, 32'hFFFF_FFFF, 16'd65535, 15'd1);
        9: set_limiter(24'(1 + $urandom_range(8388607)), 32'd16777216, 16'd0, 15'd32767);
        default: set_limiter(24'(1 + $urandom_range(8388607)),
                             32'd16777216 + $urandom_range(ph[0] ? 4000000 : 3000),
                             16'($urandom_range(40)), 15'(1 + $urandom_range(15)));
      endcase
      if (ph == 5) reg_write({REG_SCALE, 2'b00}, $urandom);
      if (ph == 2) hold_go <= 1'b1;
      n = 0;
      while (n < 110) begin
        style = $urandom_range(3);
        for (int k = $urandom_range(20, 1); k > 0 && n < 110; k--) begin
          send_sample(random_sample(style));
          n++;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("lookahead_peak_limiter_core regression: pass");
    end else begin
      $display("lookahead_peak_limiter_core regression: fail");
    end
    $finish;
  end
endmodule
